>>> hdl/ili_pkg.sv
// Shared types and codes for the indexed list with insert and delete.
package ili_pkg;

	localparam int DATA_W = 32;
	localparam int POS_W  = 7;
	localparam int LEN_W  = 7;
	localparam int DEFAULT_CAPACITY = 64;

	localparam logic [2:0] MODE_READ   = 3'd0;
	localparam logic [2:0] MODE_FRONT  = 3'd1;
	localparam logic [2:0] MODE_APPEND = 3'd2;
	localparam logic [2:0] MODE_INSERT = 3'd3;
	localparam logic [2:0] MODE_DELETE = 3'd4;

	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	localparam logic signed [DATA_W-1:0] RD_NONE = '1;

	typedef struct packed {
		logic [2:0]               mode;
		logic [POS_W-1:0]         position;
		logic signed [DATA_W-1:0] item_value;
	} in_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] read_value;
		logic [1:0]               status;
		logic [LEN_W-1:0]         length_after;
	} out_t;

	// Operation broadcast to every cell for one beat.
	typedef struct packed {
		logic ins;
		logic del;
		logic rd;
	} cell_cmd_t;

endpackage

>>> hdl/ili_cell.sv
// One storage cell of the list: holds one value and shifts with its neighbors.
module ili_cell #(
	parameter int CAPACITY = ili_pkg::DEFAULT_CAPACITY,
	parameter int INDEX    = 0
) (
	input  logic                              clk,
	input  ili_pkg::cell_cmd_t                cmd,
	input  logic [((($clog2(CAPACITY+1)) > 7) ? $clog2(CAPACITY+1) : 7)-1:0] slot,
	input  logic signed [ili_pkg::DATA_W-1:0] ins_value,
	input  logic signed [ili_pkg::DATA_W-1:0] lower,
	input  logic signed [ili_pkg::DATA_W-1:0] upper,
	output logic signed [ili_pkg::DATA_W-1:0] value,
	output logic signed [ili_pkg::DATA_W-1:0] tap
);
	import ili_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int WW    = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam logic [WW-1:0] IDX = WW'(INDEX);

	logic signed [DATA_W-1:0] val_q;

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (IDX > slot) begin
				val_q <= lower;
			end else if (IDX == slot) begin
				val_q <= ins_value;
			end
		end else if (cmd.del && (IDX >= slot)) begin
			val_q <= upper;
		end
	end

	assign value = val_q;
	assign tap   = (cmd.rd && (IDX == slot)) ? val_q : '0;

endmodule

>>> hdl/ili_ctrl.sv
// Operation decode, range checks and the length counter of the list.
module ili_ctrl #(
	parameter int CAPACITY = ili_pkg::DEFAULT_CAPACITY
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  ili_pkg::in_t         req,
	output ili_pkg::cell_cmd_t   cmd,
	output logic [((($clog2(CAPACITY+1)) > 7) ? $clog2(CAPACITY+1) : 7)-1:0] slot,
	output logic [1:0]           status,
	output logic [ili_pkg::LEN_W-1:0] len_next
);
	import ili_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int WW    = (CNT_W > POS_W) ? CNT_W : POS_W;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_next;
	logic [WW-1:0]    pos_w;
	logic [WW-1:0]    cnt_w;
	logic             full;
	logic             ins;
	logic             del;
	logic             rd;

	assign pos_w = WW'(req.position);
	assign cnt_w = WW'(count_q);
	assign full  = (count_q == CNT_W'(CAPACITY));

	always_comb begin
		ins    = 1'b0;
		del    = 1'b0;
		rd     = 1'b0;
		slot   = pos_w;
		status = ST_DONE;
		unique case (req.mode)
			MODE_READ: begin
				if (pos_w < cnt_w) rd = 1'b1;
				else status = ST_INVALID;
			end
			MODE_FRONT: begin
				slot = '0;
				if (full) status = ST_FULL;
				else ins = 1'b1;
			end
			MODE_APPEND: begin
				slot = cnt_w;
				if (full) status = ST_FULL;
				else ins = 1'b1;
			end
			MODE_INSERT: begin
				// The position check wins over the full check.
				if (pos_w > cnt_w) status = ST_INVALID;
				else if (full) status = ST_FULL;
				else ins = 1'b1;
			end
			MODE_DELETE: begin
				if (pos_w < cnt_w) del = 1'b1;
				else status = ST_INVALID;
			end
			default: begin
				status = ST_INVALID;
			end
		endcase
	end

	always_comb begin
		count_next = count_q;
		if (ins) count_next = count_q + CNT_W'(1);
		else if (del) count_next = count_q - CNT_W'(1);
	end

	assign len_next = LEN_W'(count_next);

	assign cmd.ins = accept && ins;
	assign cmd.del = accept && del;
	assign cmd.rd  = accept && rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_next;
		end
	end

endmodule

>>> hdl/indexed_list_insert_delete.sv
// A result beat is valid in the cycle after its input beat is accepted.
// Throughput: one beat per cycle while not stalled; every cell compares its index and shifts in parallel.
// A full output register stalls the input only while the output side stalls.
// Reset clears the length and the output valid; cell contents stay unknown
// and are never read before being written.
module indexed_list_insert_delete #(
	parameter int CAPACITY = ili_pkg::DEFAULT_CAPACITY
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  ili_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_stall,
	output ili_pkg::out_t out_data
);
	import ili_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int WW    = (CNT_W > POS_W) ? CNT_W : POS_W;

	logic                     accept;
	cell_cmd_t                cmd;
	logic [WW-1:0]            slot;
	logic [1:0]               status;
	logic [LEN_W-1:0]         len_next;
	logic signed [DATA_W-1:0] cell_val [CAPACITY];
	logic signed [DATA_W-1:0] cell_tap [CAPACITY];
	logic signed [DATA_W-1:0] tap_or;
	logic                     out_valid_q;
	out_t                     result_q;

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	ili_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.req      (in_data),
		.cmd      (cmd),
		.slot     (slot),
		.status   (status),
		.len_next (len_next)
	);

	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		logic signed [DATA_W-1:0] lower;
		logic signed [DATA_W-1:0] upper;
		if (k == 0) begin : g_first
			assign lower = '0;
		end else begin : g_mid_lo
			assign lower = cell_val[k-1];
		end
		if (k == CAPACITY - 1) begin : g_last
			assign upper = '0;
		end else begin : g_mid_hi
			assign upper = cell_val[k+1];
		end
		ili_cell #(.CAPACITY(CAPACITY), .INDEX(k)) u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.slot      (slot),
			.ins_value (in_data.item_value),
			.lower     (lower),
			.upper     (upper),
			.value     (cell_val[k]),
			.tap       (cell_tap[k])
		);
	end

	// At most one cell drives a nonzero tap on a read beat.
	always_comb begin
		tap_or = '0;
		for (int k = 0; k < CAPACITY; k++) begin
			tap_or = tap_or | cell_tap[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q.read_value   <= cmd.rd ? tap_or : RD_NONE;
			result_q.status       <= status;
			result_q.length_after <= len_next;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = result_q;

endmodule

>>> dv/tb_top.sv
// Testbench for the indexed list: a directed table, then phased random traffic.
module tb_top;
	import ili_pkg::*;

	localparam int CAP       = DEFAULT_CAPACITY;
	localparam int RAND_OPS  = 1140;
	localparam int HOLD_LEN  = 300;
	localparam int CYCLE_CAP = 400000;
	localparam int POS_MAX   = (1 << POS_W) - 1;

	// Mode codes the block does not define; they must be rejected.
	localparam logic [2:0] MODE_SPARE_LO = 3'd5;
	localparam logic [2:0] MODE_SPARE_HI = 3'd7;

	typedef enum int {PH_GROW, PH_SHRINK, PH_MIX} phase_e;

	typedef struct {
		logic [2:0]               mode;
		logic [POS_W-1:0]         position;
		logic signed [DATA_W-1:0] item_value;
		int                       reps;
		bit                       typed;
		out_t                     res;
	} plan_row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_t  in_data;
	logic out_valid;
	logic out_stall;
	out_t out_data;

	logic signed [DATA_W-1:0] seq_vals [CAP];
	int   seq_len;
	out_t op_replies [$];
	out_t want;
	int   mismatches = 0;
	int   cycles = 0;
	bit   snd_quiet = 0;
	bit   rcv_quiet = 0;
	bit   hold_now = 0;

	// Cumulative percent cut points for read, front, append, insert, delete; the rest is spare modes.
	int mode_cut [3][5] = '{
		'{15, 35, 55, 90, 98},
		'{20, 28, 35, 45, 98},
		'{25, 40, 55, 75, 98}
	};

	// Typed rows carry their expected result in the table; the others take it from the shadow list.
	plan_row_t plan [25] = '{
		'{MODE_READ,     7'd0,   32'sd0,           1,  1'b1, '{RD_NONE, ST_INVALID, 7'd0}},
		'{MODE_DELETE,   7'd0,   32'sd0,           1,  1'b1, '{RD_NONE, ST_INVALID, 7'd0}},
		'{MODE_INSERT,   7'd1,   32'sd7,           1,  1'b1, '{RD_NONE, ST_INVALID, 7'd0}},
		'{MODE_APPEND,   7'd0,   32'sh7fffffff,    1,  1'b1, '{RD_NONE, ST_DONE, 7'd1}},
		'{MODE_FRONT,    7'd0,   32'sh80000000,    1,  1'b1, '{RD_NONE, ST_DONE, 7'd2}},
		'{MODE_INSERT,   7'd1,   32'sd0,           1,  1'b0, '0},
		'{MODE_INSERT,   7'd3,   32'shffffffff,    1,  1'b0, '0},
		'{MODE_READ,     7'd0,   32'sd0,           1,  1'b1, '{32'sh80000000, ST_DONE, 7'd4}},
		'{MODE_READ,     7'd3,   32'sd0,           1,  1'b1, '{RD_NONE, ST_DONE, 7'd4}},
		'{MODE_READ,     7'd4,   32'sd0,           1,  1'b1, '{RD_NONE, ST_INVALID, 7'd4}},
		'{MODE_READ,     7'd127, 32'sd0,           1,  1'b1, '{RD_NONE, ST_INVALID, 7'd4}},
		'{MODE_INSERT,   7'd127, 32'sd5,           1,  1'b1, '{RD_NONE, ST_INVALID, 7'd4}},
		'{MODE_SPARE_LO, 7'd0,   32'sd9,           1,  1'b1, '{RD_NONE, ST_INVALID, 7'd4}},
		'{MODE_SPARE_HI, 7'd127, 32'shffffffff,    1,  1'b1, '{RD_NONE, ST_INVALID, 7'd4}},
		'{MODE_DELETE,   7'd127, 32'sd0,           1,  1'b1, '{RD_NONE, ST_INVALID, 7'd4}},
		'{MODE_DELETE,   7'd0,   32'sd0,           1,  1'b0, '0},
		'{MODE_DELETE,   7'd2,   32'sd0,           1,  1'b0, '0},
		'{MODE_APPEND,   7'd0,   32'sh55555555,    70, 1'b0, '0},
		'{MODE_FRONT,    7'd0,   32'sd1,           1,  1'b1, '{RD_NONE, ST_FULL, 7'd64}},
		'{MODE_INSERT,   7'd64,  32'sd2,           1,  1'b1, '{RD_NONE, ST_FULL, 7'd64}},
		'{MODE_INSERT,   7'd65,  32'sd3,           1,  1'b1, '{RD_NONE, ST_INVALID, 7'd64}},
		'{MODE_READ,     7'd63,  32'sd0,           1,  1'b0, '0},
		'{MODE_DELETE,   7'd63,  32'sd0,           1,  1'b0, '0},
		'{MODE_INSERT,   7'd10,  32'shaaaaaaaa,    1,  1'b0, '0},
		'{MODE_DELETE,   7'd0,   32'sd0,           70, 1'b0, '0}
	};

	indexed_list_insert_delete dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	function automatic void flag_error(string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%s", msg);
	endfunction

	function automatic void open_slot(int slot, logic signed [DATA_W-1:0] v);
		for (int k = seq_len; k > slot; k--)
			seq_vals[k] = seq_vals[k-1];
		seq_vals[slot] = v;
		seq_len++;
	endfunction

	// Applies one operation to the shadow list and returns the beat the block should send.
	function automatic out_t apply_list_op(in_t op);
		out_t r;
		bit   full;
		int   p;
		r.read_value = RD_NONE;
		r.status = ST_DONE;
		full = (seq_len >= CAP);
		p = op.position;
		case (op.mode)
			MODE_READ: begin
				if (p < seq_len)
					r.read_value = seq_vals[p];
				else
					r.status = ST_INVALID;
			end
			MODE_FRONT: begin
				if (full)
					r.status = ST_FULL;
				else
					open_slot(0, op.item_value);
			end
			MODE_APPEND: begin
				if (full)
					r.status = ST_FULL;
				else
					open_slot(seq_len, op.item_value);
			end
			MODE_INSERT: begin
				if (p > seq_len)
					r.status = ST_INVALID;
				else if (full)
					r.status = ST_FULL;
				else
					open_slot(p, op.item_value);
			end
			MODE_DELETE: begin
				if (p < seq_len) begin
					for (int k = p; k + 1 < seq_len; k++)
						seq_vals[k] = seq_vals[k+1];
					seq_len--;
				end else begin
					r.status = ST_INVALID;
				end
			end
			default: r.status = ST_INVALID;
		endcase
		r.length_after = LEN_W'(seq_len);
		return r;
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(15))
			0: return '0;
			1: return '1;
			2: return 32'sh7fffffff;
			3: return 32'sh80000000;
			default: return $urandom;
		endcase
	endfunction

	function automatic in_t pick_op(phase_e ph);
		in_t op;
		int  roll;
		roll = $urandom_range(99);
		if (roll < mode_cut[ph][0])
			op.mode = MODE_READ;
		else if (roll < mode_cut[ph][1])
			op.mode = MODE_FRONT;
		else if (roll < mode_cut[ph][2])
			op.mode = MODE_APPEND;
		else if (roll < mode_cut[ph][3])
			op.mode = MODE_INSERT;
		else if (roll < mode_cut[ph][4])
			op.mode = MODE_DELETE;
		else
			op.mode = 3'($urandom_range(MODE_SPARE_HI, MODE_SPARE_LO));
		op.item_value = pick_value();
		// Mostly legal positions, with the one-past-the-end boundary and wild ones mixed in.
		roll = $urandom_range(99);
		if (roll >= 85)
			op.position = POS_W'($urandom_range(POS_MAX));
		else if (roll >= 75)
			op.position = POS_W'(seq_len);
		else if (op.mode == MODE_INSERT)
			op.position = POS_W'($urandom_range(seq_len, 0));
		else if (seq_len > 0)
			op.position = POS_W'($urandom_range(seq_len - 1, 0));
		else
			op.position = '0;
		return op;
	endfunction

	// Offers one beat, after a random gap unless the sender is quiet, and records its result once the block takes it.
	task automatic push_beat(input in_t op, input bit typed, input out_t typed_res,
			output out_t pred);
		int gap;
		gap = snd_quiet ? 0 : $urandom_range(19);
		if (gap > 0) begin
			in_valid = 0;
			repeat (gap) @(negedge clk);
		end
		in_data = op;
		in_valid = 1;
		do @(posedge clk); while (in_stall);
		pred = apply_list_op(op);
		op_replies.push_back(typed ? typed_res : pred);
		@(negedge clk);
	endtask

	// Result side: random stall before each beat unless quiet, plus one long hold-off on request.
	initial begin
		int w;
		int seen;
		out_stall = 0;
		seen = 0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (hold_now) begin
				out_stall = 1;
				repeat (HOLD_LEN) @(negedge clk);
				hold_now = 0;
			end
			if (seen % 50 == 0)
				rcv_quiet = ($urandom_range(3) == 0);
			w = rcv_quiet ? 0 : $urandom_range(19);
			if (w > 0) begin
				out_stall = 1;
				repeat (w) @(negedge clk);
			end
			out_stall = 0;
			do @(posedge clk); while (!out_valid);
			seen++;
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (op_replies.size() == 0) begin
				flag_error($sformatf("unexpected beat: read_value %0d status %0d length %0d",
					out_data.read_value, out_data.status, out_data.length_after));
			end else begin
				want = op_replies.pop_front();
				if (out_data.read_value !== want.read_value || out_data.status !== want.status
						|| out_data.length_after !== want.length_after)
					flag_error($sformatf(
						"mismatch: read_value %0d/%0d status %0d/%0d length %0d/%0d (exp/got)",
						want.read_value, out_data.read_value, want.status, out_data.status,
						want.length_after, out_data.length_after));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("indexed_list_insert_delete regression: fail");
			$finish;
		end
	end

	initial begin
		in_t    op;
		out_t   pred;
		int     n;
		int     phase_left;
		phase_e ph;
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		seq_len = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		foreach (plan[r]) begin
			for (int k = 0; k < plan[r].reps; k++) begin
				op.mode = plan[r].mode;
				op.position = plan[r].position;
				op.item_value = plan[r].item_value + k;
				push_beat(op, plan[r].typed, plan[r].res, pred);
			end
		end

		// Random phases that grow the list toward full, shrink it toward empty, or churn it.
		n = 0;
		phase_left = 0;
		ph = PH_MIX;
		while (n < RAND_OPS) begin
			if (phase_left == 0) begin
				ph = phase_e'($urandom_range(2));
				phase_left = $urandom_range(120, 40);
			end
			if (n % 50 == 0)
				snd_quiet = ($urandom_range(3) == 0);
			if (n == 400)
				hold_now = 1;
			if (n == 900) begin
				in_valid = 0;
				while (op_replies.size() != 0) @(posedge clk);
				@(negedge clk);
			end
			push_beat(pick_op(ph), 1'b0, '0, pred);
			n++;
			phase_left--;
		end
		in_valid = 0;

		while (op_replies.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("indexed_list_insert_delete regression: pass");
		else
			$display("indexed_list_insert_delete regression: fail");
		$finish;
	end

endmodule
